@@ src/line_pixel_generator_defines.svh @@
// ----------------------------------------------------------------------------
// line_pixel_generator_defines
// Assertion macros used by the checker file of the line pixel generator.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define LPG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Delayed implication.
`define LPG_ASSERT_DELAY2(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

@@ src/lpg_pkg.sv @@
// ----------------------------------------------------------------------------
// lpg_pkg
// Types, constants and control structs of the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_BITS = 6;
    localparam int COLOR_BITS = 24;
    // error term holds up to 4 * max delta
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COLOR_BITS-1:0] color_t;
    typedef logic [ERR_BITS-1:0]   err_t;

    typedef enum logic [2:0] {
        MODE_VERT          = 3'd0,
        MODE_HORIZ         = 3'd1,
        MODE_SHALLOW_UP    = 3'd2,
        MODE_SHALLOW_DOWN  = 3'd3,
        MODE_STEEP_UP      = 3'd4,
        MODE_STEEP_DOWN    = 3'd5
    } walk_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SETUP = 2'd1,
        ST_WALK  = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } lpg_cmd_t;

    typedef struct packed {
        logic last;
    } lpg_status_t;

endpackage

@@ src/lpg_seg_if.sv @@
// ----------------------------------------------------------------------------
// lpg_seg_if
// Segment channel: two endpoints and a color, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpg_seg_if;
    logic            valid;
    logic            ready;
    lpg_pkg::coord_t x_start;
    lpg_pkg::coord_t y_start;
    lpg_pkg::coord_t x_end;
    lpg_pkg::coord_t y_end;
    lpg_pkg::color_t line_color;

    modport source (output valid, x_start, y_start, x_end, y_end, line_color,
                    input ready);
    modport sink   (input valid, x_start, y_start, x_end, y_end, line_color,
                    output ready);
endinterface

@@ src/lpg_pix_if.sv @@
// ----------------------------------------------------------------------------
// lpg_pix_if
// Pixel channel: one pixel with its color and end-of-segment mark.
// ----------------------------------------------------------------------------
interface lpg_pix_if;
    logic            valid;
    logic            ready;
    lpg_pkg::coord_t pixel_x;
    lpg_pkg::coord_t pixel_y;
    lpg_pkg::color_t pixel_color;
    logic            last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    output ready);
endinterface

@@ src/lpg_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpg_ctrl
// Sequencer: takes a segment, passes a setup state, then walks its pixels.
// ----------------------------------------------------------------------------
module lpg_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  lpg_pkg::lpg_status_t status,
    output lpg_pkg::lpg_cmd_t    cmd
);

    lpg_pkg::ctrl_state_t state_reg;
    lpg_pkg::ctrl_state_t state_next;
    logic                 in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_take = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpg_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = lpg_pkg::ST_SETUP;
                end
            end
            lpg_pkg::ST_SETUP:
            begin
                state_next = lpg_pkg::ST_WALK;
            end
            lpg_pkg::ST_WALK:
            begin
                if (out_ready && status.last)
                begin
                    state_next = in_take ? lpg_pkg::ST_SETUP : lpg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.setup  = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            lpg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            lpg_pkg::ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            lpg_pkg::ST_WALK:
            begin
                out_valid = 1'b1;
                // take the next segment as the final pixel leaves
                in_ready  = out_ready && status.last;
                cmd.step  = out_ready && !status.last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.load = in_valid && in_ready;
    end

endmodule

@@ src/lpg_datapath.sv @@
// ----------------------------------------------------------------------------
// lpg_datapath
// Endpoint registers, setup logic and the error-term walker.
// ----------------------------------------------------------------------------
module lpg_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpg_pkg::lpg_cmd_t    cmd,
    input  lpg_pkg::coord_t      x_start,
    input  lpg_pkg::coord_t      y_start,
    input  lpg_pkg::coord_t      x_end,
    input  lpg_pkg::coord_t      y_end,
    input  lpg_pkg::color_t      line_color,
    output lpg_pkg::coord_t      pixel_x,
    output lpg_pkg::coord_t      pixel_y,
    output lpg_pkg::color_t      pixel_color,
    output lpg_pkg::lpg_status_t status
);

    lpg_pkg::coord_t     xs_reg, ys_reg, xe_reg, ye_reg;
    lpg_pkg::color_t     color_reg;
    lpg_pkg::walk_mode_t mode_reg, mode_next;
    lpg_pkg::coord_t     cur_x_reg, cur_x_next;
    lpg_pkg::coord_t     cur_y_reg, cur_y_next;
    lpg_pkg::coord_t     steps_reg, steps_next;
    lpg_pkg::coord_t     major_reg, major_next;
    lpg_pkg::coord_t     minor_reg, minor_next;
    lpg_pkg::err_t       err_reg, err_next;

    // setup terms
    lpg_pkg::coord_t     lx, ly, rx, ry, dx, ady;
    lpg_pkg::walk_mode_t s_mode;
    lpg_pkg::coord_t     s_x, s_y, s_major, s_minor;
    // walk terms
    lpg_pkg::err_t       err_sum, major_x2;
    logic                minor_move;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xs_reg    <= x_start;
            ys_reg    <= y_start;
            xe_reg    <= x_end;
            ye_reg    <= y_end;
            color_reg <= line_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= lpg_pkg::MODE_VERT;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            steps_reg <= '0;
            major_reg <= '0;
            minor_reg <= '0;
            err_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            steps_reg <= steps_next;
            major_reg <= major_next;
            minor_reg <= minor_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        if (xs_reg < xe_reg)
        begin
            lx = xs_reg;
            ly = ys_reg;
            rx = xe_reg;
            ry = ye_reg;
        end
        else
        begin
            lx = xe_reg;
            ly = ye_reg;
            rx = xs_reg;
            ry = ys_reg;
        end
        dx      = rx - lx;
        ady     = (ry > ly) ? (ry - ly) : (ly - ry);
        s_minor = '0;
        s_x     = lx;
        s_y     = ly;
        if (xs_reg == xe_reg)
        begin
            s_mode  = lpg_pkg::MODE_VERT;
            s_x     = xs_reg;
            s_y     = (ys_reg < ye_reg) ? ys_reg : ye_reg;
            s_major = (ys_reg < ye_reg) ? (ye_reg - ys_reg) : (ys_reg - ye_reg);
        end
        else if (ys_reg == ye_reg)
        begin
            s_mode  = lpg_pkg::MODE_HORIZ;
            s_y     = ys_reg;
            s_major = dx;
        end
        else if (ady <= dx)
        begin
            s_mode  = (ry > ly) ? lpg_pkg::MODE_SHALLOW_UP : lpg_pkg::MODE_SHALLOW_DOWN;
            s_major = dx;
            s_minor = ady;
        end
        else
        begin
            s_mode  = (ry > ly) ? lpg_pkg::MODE_STEEP_UP : lpg_pkg::MODE_STEEP_DOWN;
            s_major = ady;
            s_minor = dx;
        end
    end

    assign major_x2   = {2'b00, major_reg, 1'b0};
    assign err_sum    = err_reg + {2'b00, minor_reg, 1'b0};
    assign minor_move = (err_sum >= major_x2);

    always_comb
    begin
        mode_next  = mode_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        steps_next = steps_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        err_next   = err_reg;
        if (cmd.setup)
        begin
            mode_next  = s_mode;
            cur_x_next = s_x;
            cur_y_next = s_y;
            steps_next = s_major;
            major_next = s_major;
            minor_next = s_minor;
            // falling shallow lines bias by one so an exact half stays high
            if (s_mode == lpg_pkg::MODE_SHALLOW_DOWN)
            begin
                err_next = {3'b000, s_major} - lpg_pkg::err_t'(1);
            end
            else
            begin
                err_next = {3'b000, s_major};
            end
        end
        else if (cmd.step)
        begin
            steps_next = steps_reg - lpg_pkg::coord_t'(1);
            err_next   = minor_move ? (err_sum - major_x2) : err_sum;
            case (mode_reg)
                lpg_pkg::MODE_HORIZ:
                begin
                    cur_x_next = cur_x_reg + lpg_pkg::coord_t'(1);
                end
                lpg_pkg::MODE_SHALLOW_UP:
                begin
                    cur_x_next = cur_x_reg + lpg_pkg::coord_t'(1);
                    cur_y_next = cur_y_reg + lpg_pkg::coord_t'(minor_move);
                end
                lpg_pkg::MODE_SHALLOW_DOWN:
                begin
                    cur_x_next = cur_x_reg + lpg_pkg::coord_t'(1);
                    cur_y_next = cur_y_reg - lpg_pkg::coord_t'(minor_move);
                end
                lpg_pkg::MODE_STEEP_UP:
                begin
                    cur_y_next = cur_y_reg + lpg_pkg::coord_t'(1);
                    cur_x_next = cur_x_reg + lpg_pkg::coord_t'(minor_move);
                end
                lpg_pkg::MODE_STEEP_DOWN:
                begin
                    cur_y_next = cur_y_reg - lpg_pkg::coord_t'(1);
                    cur_x_next = cur_x_reg + lpg_pkg::coord_t'(minor_move);
                end
                default:
                begin
                    cur_y_next = cur_y_reg + lpg_pkg::coord_t'(1);
                end
            endcase
        end
    end

    assign pixel_x     = cur_x_reg;
    assign pixel_y     = cur_y_reg;
    assign pixel_color = color_reg;
    assign status.last = (steps_reg == '0);

endmodule

@@ src/line_pixel_generator.sv @@
// ----------------------------------------------------------------------------
// line_pixel_generator
// Line rasterizer: one segment in, its pixels out in order, last one marked.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                       handshake
//  seg       in    x_start, y_start, x_end, y_end, line_color    valid/ready
//  pix       out   pixel_x, pixel_y, pixel_color, last_pixel     valid/ready
//
//  A segment of N pixels (N = longer axis delta + 1, at most 64) takes a setup
//  state, then one pixel per cycle from the walk registers while not stalled.
//  The next segment is taken in the cycle its predecessor's last pixel leaves.
//  A low pix.ready holds the current pixel; seg.ready stays low until then.
//  rst_n clears the sequencer and walk state asynchronously.
// ----------------------------------------------------------------------------
module line_pixel_generator
(
    input  logic       clk,
    input  logic       rst_n,
    lpg_seg_if.sink    seg,
    lpg_pix_if.source  pix
);

    lpg_pkg::lpg_cmd_t    cmd;
    lpg_pkg::lpg_status_t status;

    lpg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg.valid),
        .in_ready  (seg.ready),
        .out_valid (pix.valid),
        .out_ready (pix.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lpg_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .x_start     (seg.x_start),
        .y_start     (seg.y_start),
        .x_end       (seg.x_end),
        .y_end       (seg.y_end),
        .line_color  (seg.line_color),
        .pixel_x     (pix.pixel_x),
        .pixel_y     (pix.pixel_y),
        .pixel_color (pix.pixel_color),
        .status      (status)
    );

    assign pix.last_pixel = status.last;

endmodule

@@ src/lpg_checker.sv @@
// ----------------------------------------------------------------------------
// lpg_checker
// Port-level checks on the line pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_pixel_generator_defines.svh"

module lpg_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            seg_valid,
    input logic            seg_ready,
    input logic            pix_valid,
    input logic            pix_ready,
    input lpg_pkg::coord_t pixel_x,
    input lpg_pkg::coord_t pixel_y,
    input lpg_pkg::color_t pixel_color,
    input logic            last_pixel
);

    logic seg_take;
    logic pix_hold;

    assign seg_take = seg_valid && seg_ready;
    assign pix_hold = pix_valid && !pix_ready;

    `LPG_ASSERT_NEXT(a_pix_hold, pix_hold, pix_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color) && $stable(last_pixel), "pixel changed while stalled")
    `LPG_ASSERT_NEXT(a_setup_gap, seg_take, !pix_valid, "pixel shown in the setup cycle")
    `LPG_ASSERT_DELAY2(a_first_pixel, seg_take, pix_valid, "first pixel not shown after setup")
    `LPG_ASSERT_IMPL(a_no_early_take, pix_valid && !last_pixel, !seg_ready, "segment taken mid-walk")
    `LPG_ASSERT_NEXT(a_walk_continues, pix_valid && pix_ready && !last_pixel, pix_valid, "walk stopped before the last pixel")

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .seg_valid   (seg.valid),
    .seg_ready   (seg.ready),
    .pix_valid   (pix.valid),
    .pix_ready   (pix.ready),
    .pixel_x     (pix.pixel_x),
    .pixel_y     (pix.pixel_y),
    .pixel_color (pix.pixel_color),
    .last_pixel  (pix.last_pixel)
);
